[src/l2hct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2hct_pkg: shared types and constants for the header compression table
// Item layouts, table entry layout, table geometry and the header hash.
// ----------------------------------------------------------------------------
package l2hct_pkg;

    // Table geometry: one bank of entries per direction
    localparam int ENTRIES_PER_DIRECTION = 256;
    localparam int TABLE_DEPTH           = 2 * ENTRIES_PER_DIRECTION;
    localparam int ADDR_W                = $clog2(TABLE_DEPTH);
    localparam int ID_W                  = $clog2(ENTRIES_PER_DIRECTION);

    // Packet count and the residues kept beside it for the send decision
    localparam int COUNT_W    = 32;
    localparam int MOD_A      = 50;
    localparam int MOD_B      = 20;
    localparam int MOD_C_BITS = 3;
    localparam int MIN_C      = 3;
    localparam int RES_A_W    = $clog2(MOD_A);
    localparam int RES_B_W    = $clog2(MOD_B);

    // Header field widths
    localparam int MAC_W  = 48;
    localparam int TYPE_W = 16;

    // Mode codes
    localparam logic MODE_CLASSIFY   = 1'b0;
    localparam logic MODE_DECOMPRESS = 1'b1;

    typedef struct packed {
        logic              mode;
        logic              direction;
        logic [MAC_W-1:0]  dst_mac;
        logic [MAC_W-1:0]  src_mac;
        logic [TYPE_W-1:0] ether_type;
        logic [ID_W-1:0]   session_id;
    } in_item_t;

    typedef struct packed {
        logic              send_compressed;
        logic [ID_W-1:0]   hash_id;
        logic              collision;
        logic [MAC_W-1:0]  out_dst_mac;
        logic [MAC_W-1:0]  out_src_mac;
        logic [TYPE_W-1:0] out_ether_type;
    } out_item_t;

    // One table entry; an all-zero word is an empty entry
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [RES_A_W-1:0] res_a;
        logic [RES_B_W-1:0] res_b;
        logic [MAC_W-1:0]   dst;
        logic [MAC_W-1:0]   src;
        logic [TYPE_W-1:0]  typ;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Entry update and result from the compute stage
    typedef struct packed {
        logic      wr_en;
        entry_t    wr_entry;
        out_item_t res;
    } upd_t;

    // XOR of all header bytes
    function automatic logic [ID_W-1:0] header_hash(
        input logic [MAC_W-1:0]  dst,
        input logic [MAC_W-1:0]  src,
        input logic [TYPE_W-1:0] typ
    );
        logic [ID_W-1:0] h;
        h = '0;
        for (int k = 0; k < MAC_W / 8; k++)
        begin
            h = h ^ dst[k*8 +: 8] ^ src[k*8 +: 8];
        end
        for (int k = 0; k < TYPE_W / 8; k++)
        begin
            h = h ^ typ[k*8 +: 8];
        end
        return h;
    endfunction

endpackage

[src/l2hct_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2hct_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on a
// same-address write in the same cycle).
// ----------------------------------------------------------------------------
module l2hct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/l2hct_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2hct_update: entry update and result logic
// In classify mode compares the item header with the current entry, advances
// or replaces the count, decides on compression; forms the result item.
// ----------------------------------------------------------------------------
module l2hct_update (
    input  l2hct_pkg::in_item_t          item,
    input  logic [l2hct_pkg::ID_W-1:0]   hash,
    input  l2hct_pkg::entry_t            cur,
    output l2hct_pkg::upd_t              upd
);

    logic                          match;
    logic                          sat;
    logic [l2hct_pkg::COUNT_W-1:0] cnt_next;
    logic [l2hct_pkg::RES_A_W-1:0] res_a_next;
    logic [l2hct_pkg::RES_B_W-1:0] res_b_next;
    logic                          decide;
    l2hct_pkg::entry_t             fresh;
    l2hct_pkg::entry_t             bumped;

    // Compare the stored header
    assign match = cur.valid
                && (cur.dst == item.dst_mac)
                && (cur.src == item.src_mac)
                && (cur.typ == item.ether_type);

    // Advance the count and its residues, saturating at the top
    assign sat = (cur.count == {l2hct_pkg::COUNT_W{1'b1}});

    always_comb
    begin
        cnt_next   = cur.count;
        res_a_next = cur.res_a;
        res_b_next = cur.res_b;
        if (!sat)
        begin
            cnt_next   = cur.count + l2hct_pkg::COUNT_W'(1);
            res_a_next = (cur.res_a == l2hct_pkg::RES_A_W'(l2hct_pkg::MOD_A - 1))
                       ? '0 : cur.res_a + l2hct_pkg::RES_A_W'(1);
            res_b_next = (cur.res_b == l2hct_pkg::RES_B_W'(l2hct_pkg::MOD_B - 1))
                       ? '0 : cur.res_b + l2hct_pkg::RES_B_W'(1);
        end
    end

    // Decide on compression from the new count
    assign decide =
        ((cnt_next > l2hct_pkg::COUNT_W'(l2hct_pkg::MOD_A)) && (res_a_next != '0))
     || ((cnt_next > l2hct_pkg::COUNT_W'(l2hct_pkg::MOD_B)) && (res_b_next != '0))
     || ((cnt_next > l2hct_pkg::COUNT_W'(l2hct_pkg::MIN_C))
         && (cnt_next[l2hct_pkg::MOD_C_BITS-1:0] != '0));

    // New entry for an empty or mismatching slot, count one
    always_comb
    begin
        fresh       = '0;
        fresh.valid = 1'b1;
        fresh.count = l2hct_pkg::COUNT_W'(1);
        fresh.res_a = l2hct_pkg::RES_A_W'(1);
        fresh.res_b = l2hct_pkg::RES_B_W'(1);
        fresh.dst   = item.dst_mac;
        fresh.src   = item.src_mac;
        fresh.typ   = item.ether_type;

        bumped       = cur;
        bumped.count = cnt_next;
        bumped.res_a = res_a_next;
        bumped.res_b = res_b_next;
    end

    // Form the write and the result item
    always_comb
    begin
        upd = '0;
        if (item.mode == l2hct_pkg::MODE_DECOMPRESS)
        begin
            upd.wr_en              = 1'b0;
            upd.wr_entry           = cur;
            upd.res.hash_id        = item.session_id;
            upd.res.out_dst_mac    = cur.dst;
            upd.res.out_src_mac    = cur.src;
            upd.res.out_ether_type = cur.typ;
        end
        else
        begin
            upd.wr_en               = 1'b1;
            upd.wr_entry            = match ? bumped : fresh;
            upd.res.hash_id         = hash;
            upd.res.send_compressed = match && decide;
            upd.res.collision       = cur.valid && !match;
        end
    end

endmodule

[src/l2_header_compression_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2_header_compression_table: layer 2 header compression context table
// Classifies Ethernet headers into per-direction session entries and
// restores stored headers by session id.
// ----------------------------------------------------------------------------
//  channel  | signals                          | role
//  ---------+----------------------------------+---------------------------
//  item     | item_valid, item_ready, item     | header or session id in
//  result   | result_valid, result_ready,      | one result per item out
//           | result                           |
//
//  One item per cycle while results are not stalled; the table read and
//  the item capture share the accepting edge, and compute and write-back
//  land in the result register when the compute stage advances.
//  A write-back to the entry being read in the same cycle is forwarded.
//  After reset a clearing pass writes all 512 entries, one per cycle,
//  with item_ready low until the pass ends.
//  A stalled result holds the compute stage; item_ready follows it.
// ----------------------------------------------------------------------------
module l2_header_compression_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  l2hct_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output l2hct_pkg::out_item_t result
);

    // Control state
    logic                           clr_busy_reg,   clr_busy_next;
    logic [l2hct_pkg::ADDR_W-1:0]   clr_addr_reg,   clr_addr_next;
    logic                           s1_valid_reg,   s1_valid_next;
    logic                           res_valid_reg,  res_valid_next;

    // Payload state
    l2hct_pkg::in_item_t            s1_item_reg;
    logic [l2hct_pkg::ID_W-1:0]     s1_hash_reg;
    logic [l2hct_pkg::ADDR_W-1:0]   s1_addr_reg;
    logic                           fwd_hit_reg;
    l2hct_pkg::entry_t              fwd_entry_reg;
    l2hct_pkg::out_item_t           res_reg;

    logic                           accept;
    logic                           advance;
    logic [l2hct_pkg::ID_W-1:0]     in_hash;
    logic [l2hct_pkg::ADDR_W-1:0]   rd_addr;
    logic                           wr_en;
    logic [l2hct_pkg::ADDR_W-1:0]   wr_addr;
    l2hct_pkg::entry_t              wr_entry;
    logic [l2hct_pkg::ENTRY_W-1:0]  rd_data;
    l2hct_pkg::entry_t              cur;
    l2hct_pkg::upd_t                upd;

    // Handshakes
    assign advance    = s1_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !clr_busy_reg && (!s1_valid_reg || advance);
    assign accept     = item_valid && item_ready;

    // Hash and table address of the incoming item
    assign in_hash = l2hct_pkg::header_hash(item.dst_mac, item.src_mac, item.ether_type);
    assign rd_addr = {item.direction,
                      (item.mode == l2hct_pkg::MODE_DECOMPRESS) ? item.session_id : in_hash};

    // Write port: clearing pass, else the compute stage write-back
    always_comb
    begin
        if (clr_busy_reg)
        begin
            wr_en    = 1'b1;
            wr_addr  = clr_addr_reg;
            wr_entry = '0;
        end
        else
        begin
            wr_en    = advance && upd.wr_en;
            wr_addr  = s1_addr_reg;
            wr_entry = upd.wr_entry;
        end
    end

    l2hct_ram #(
        .WIDTH (l2hct_pkg::ENTRY_W),
        .DEPTH (l2hct_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Pick the forwarded entry when it was written as this item was read
    assign cur = fwd_hit_reg ? fwd_entry_reg : l2hct_pkg::entry_t'(rd_data);

    l2hct_update u_update (
        .item (s1_item_reg),
        .hash (s1_hash_reg),
        .cur  (cur),
        .upd  (upd)
    );

    // Next control state
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + l2hct_pkg::ADDR_W'(1);
            if (clr_addr_reg == l2hct_pkg::ADDR_W'(l2hct_pkg::TABLE_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture the item, its address and any same-cycle write-back; register the result on advance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg   <= item;
            s1_hash_reg   <= in_hash;
            s1_addr_reg   <= rd_addr;
            fwd_hit_reg   <= wr_en && (wr_addr == rd_addr);
            fwd_entry_reg <= wr_entry;
        end
        if (advance)
        begin
            res_reg <= upd.res;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
